/* src/cws_pkg.sv */
// ----------------------------------------------------------------------------
// cws_pkg
// Shared types and fixed widths for the circular window sum block.
// ----------------------------------------------------------------------------
package cws_pkg;

  // fixed field widths
  localparam int WINDOW_W = 6;
  localparam int TOTAL_W  = 21;

  // sequencer states
  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SETUP,
    ST_READ,
    ST_DRAIN,
    ST_EMIT
  } seq_state_e;

  // control from the sequencer to the datapath
  typedef struct packed {
    logic acc_clear;
    logic acc_add;
    logic emit;
    logic last;
  } seq_ctl_t;

endpackage

/* src/cws_store.sv */
// ----------------------------------------------------------------------------
// cws_store
// Sample memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module cws_store #(
  parameter int DEPTH        = 32,
  parameter int SAMPLE_WIDTH = 16,
  parameter int ADDR_W       = 5
) (
  input  logic                           clk_i,
  input  logic                           we_i,
  input  logic [ADDR_W-1:0]              waddr_i,
  input  logic signed [SAMPLE_WIDTH-1:0] wdata_i,
  input  logic [ADDR_W-1:0]              raddr_i,
  output logic signed [SAMPLE_WIDTH-1:0] rdata_o
);

  logic signed [SAMPLE_WIDTH-1:0] mem [DEPTH];
  logic signed [SAMPLE_WIDTH-1:0] rdata_q;

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* src/cws_accum.sv */
// ----------------------------------------------------------------------------
// cws_accum
// Shared adder and accumulator with saturation of the total to 21 bits.
// ----------------------------------------------------------------------------
module cws_accum #(
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  cws_pkg::seq_ctl_t                   ctl_i,
  input  logic signed [SAMPLE_WIDTH-1:0]      rdata_i,
  output logic signed [cws_pkg::TOTAL_W-1:0]  total_o
);

  localparam int ACC_W = SAMPLE_WIDTH + cws_pkg::WINDOW_W;
  localparam int CMP_W = (ACC_W > cws_pkg::TOTAL_W) ? ACC_W : cws_pkg::TOTAL_W;
  localparam logic signed [CMP_W-1:0] TOT_MAX =
    {{(CMP_W - cws_pkg::TOTAL_W + 1){1'b0}}, {(cws_pkg::TOTAL_W - 1){1'b1}}};
  localparam logic signed [CMP_W-1:0] TOT_MIN = ~TOT_MAX;

  logic signed [ACC_W-1:0] acc_q, acc_d;
  logic signed [CMP_W-1:0] acc_x;
  logic signed [CMP_W-1:0] sat;

  // accumulate one sample per read beat
  always_comb begin
    acc_d = acc_q;
    if (ctl_i.acc_clear) begin
      acc_d = '0;
    end else if (ctl_i.acc_add) begin
      acc_d = acc_q + ACC_W'(rdata_i);
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // clamp to the output range
  always_comb begin
    acc_x = CMP_W'(acc_q);
    if (acc_x > TOT_MAX) begin
      sat = TOT_MAX;
    end else if (acc_x < TOT_MIN) begin
      sat = TOT_MIN;
    end else begin
      sat = acc_x;
    end
  end

  assign total_o = sat[cws_pkg::TOTAL_W-1:0];

endmodule

/* src/cws_seq.sv */
// ----------------------------------------------------------------------------
// cws_seq
// Sequencer: loads samples, then walks every position and its window
// one memory read at a time.
// ----------------------------------------------------------------------------
module cws_seq #(
  parameter int DEPTH  = 32,
  parameter int POS_W  = 5,
  parameter int CNT_W  = 6
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  input  logic                                final_i,
  output logic                                in_ready_o,
  input  logic signed [cws_pkg::WINDOW_W-1:0] window_i,
  input  logic                                out_free_i,
  output cws_pkg::seq_ctl_t                   ctl_o,
  output logic                                wr_en_o,
  output logic [POS_W-1:0]                    wr_addr_o,
  output logic [POS_W-1:0]                    rd_addr_o,
  output logic [CNT_W-1:0]                    count_o,
  output logic                                ovf_o,
  output logic [POS_W-1:0]                    pos_o
);

  cws_pkg::seq_state_e state_q, state_d;
  logic [CNT_W-1:0]             count_q, count_d;
  logic                         ovf_q, ovf_d;
  logic [POS_W-1:0]             pos_q, pos_d;
  logic [POS_W-1:0]             idx_q, idx_d;
  logic [cws_pkg::WINDOW_W-1:0] left_q, left_d;
  logic                         rd_pend_q;
  logic [cws_pkg::WINDOW_W-1:0] cnt_abs;
  logic                         fwd;
  logic                         last;

  // next index around the ring, forward or backward
  function automatic logic [POS_W-1:0] step_idx(input logic [POS_W-1:0] idx,
                                                 input logic [CNT_W-1:0] n,
                                                 input logic dir_fwd);
    logic [POS_W-1:0] res;
    if (dir_fwd) begin
      res = (CNT_W'(idx) == n - CNT_W'(1)) ? '0 : idx + POS_W'(1);
    end else begin
      res = (idx == '0) ? POS_W'(n - CNT_W'(1)) : idx - POS_W'(1);
    end
    return res;
  endfunction

  // window length and direction
  assign cnt_abs = window_i[cws_pkg::WINDOW_W-1] ? cws_pkg::WINDOW_W'(-window_i)
                                                 : cws_pkg::WINDOW_W'(window_i);
  assign fwd  = !window_i[cws_pkg::WINDOW_W-1];
  assign last = (CNT_W'(pos_q) == count_q - CNT_W'(1));

  // next state and control
  always_comb begin
    state_d  = state_q;
    count_d  = count_q;
    ovf_d    = ovf_q;
    pos_d    = pos_q;
    idx_d    = idx_q;
    left_d   = left_q;
    wr_en_o  = 1'b0;
    ctl_o    = '0;
    ctl_o.acc_add = rd_pend_q;
    ctl_o.last    = last;
    unique case (state_q)
      cws_pkg::ST_LOAD: begin
        if (in_valid_i) begin
          if (count_q < CNT_W'(DEPTH)) begin
            wr_en_o = 1'b1;
            count_d = count_q + CNT_W'(1);
          end else begin
            ovf_d = 1'b1;
          end
          if (final_i) begin
            pos_d   = '0;
            state_d = cws_pkg::ST_SETUP;
          end
        end
      end
      cws_pkg::ST_SETUP: begin
        ctl_o.acc_clear = 1'b1;
        idx_d  = step_idx(pos_q, count_q, fwd);
        left_d = cnt_abs;
        state_d = (cnt_abs == '0) ? cws_pkg::ST_EMIT : cws_pkg::ST_READ;
      end
      cws_pkg::ST_READ: begin
        idx_d  = step_idx(idx_q, count_q, fwd);
        left_d = left_q - cws_pkg::WINDOW_W'(1);
        if (left_q == cws_pkg::WINDOW_W'(1)) begin
          state_d = cws_pkg::ST_DRAIN;
        end
      end
      cws_pkg::ST_DRAIN: begin
        state_d = cws_pkg::ST_EMIT;
      end
      cws_pkg::ST_EMIT: begin
        if (out_free_i) begin
          ctl_o.emit = 1'b1;
          if (last) begin
            count_d = '0;
            ovf_d   = 1'b0;
            state_d = cws_pkg::ST_LOAD;
          end else begin
            pos_d   = pos_q + POS_W'(1);
            state_d = cws_pkg::ST_SETUP;
          end
        end
      end
      default: begin
        state_d = cws_pkg::ST_LOAD;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= cws_pkg::ST_LOAD;
      count_q   <= '0;
      ovf_q     <= 1'b0;
      rd_pend_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      ovf_q     <= ovf_d;
      rd_pend_q <= (state_q == cws_pkg::ST_READ);
    end
  end

  // position and read pointer
  always_ff @(posedge clk_i) begin
    pos_q  <= pos_d;
    idx_q  <= idx_d;
    left_q <= left_d;
  end

  assign in_ready_o = (state_q == cws_pkg::ST_LOAD);
  assign wr_addr_o  = POS_W'(count_q);
  assign rd_addr_o  = idx_q;
  assign count_o    = count_q;
  assign ovf_o      = ovf_q;
  assign pos_o      = pos_q;

endmodule

/* src/circular_window_sum.sv */
// ----------------------------------------------------------------------------
// circular_window_sum
// Circular sliding-window sum over a loaded array of signed samples.
// ----------------------------------------------------------------------------
// Samples load at one beat per cycle until a beat marked final_sample; beats
// beyond DEPTH are dropped and reported through truncated. The block then
// emits one result per loaded position: the sum of the |window| following
// (window > 0) or preceding (window < 0) elements, wrapping around the array,
// saturated to 21 bits. All window reads go through the single read port of
// the sample memory into one shared adder, one element per cycle. Each
// position runs setup, one read per element, drain and emit (setup and emit
// alone for a zero window); input is not taken during emission. The last
// result may still wait at the output while the next array loads.
// ----------------------------------------------------------------------------
module circular_window_sum #(
  parameter int DEPTH        = 32,
  parameter int SAMPLE_WIDTH = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // configuration
  input  logic                                cfg_we_i,
  input  logic signed [cws_pkg::WINDOW_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [SAMPLE_WIDTH-1:0]      sample_i,
  input  logic                                final_sample_i,
  // output channel
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [cws_pkg::TOTAL_W-1:0]  window_total_o,
  output logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] position_o,
  output logic                                run_end_o,
  output logic                                truncated_o
);

  localparam int POS_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic signed [cws_pkg::WINDOW_W-1:0] window_q;
  cws_pkg::seq_ctl_t                   ctl;
  logic                                wr_en;
  logic [POS_W-1:0]                    wr_addr;
  logic [POS_W-1:0]                    rd_addr;
  logic [CNT_W-1:0]                    count;
  logic                                ovf;
  logic [POS_W-1:0]                    pos;
  logic signed [SAMPLE_WIDTH-1:0]      rdata;
  logic signed [cws_pkg::TOTAL_W-1:0]  total;
  logic                                out_free;

  logic                                ovalid_q;
  logic signed [cws_pkg::TOTAL_W-1:0]  total_q;
  logic [POS_W-1:0]                    pos_q;
  logic                                end_q;
  logic                                trunc_q;

  // window register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q <= '0;
    end else if (cfg_we_i) begin
      window_q <= cfg_wdata_i;
    end
  end

  assign out_free = !ovalid_q || out_ready_i;

  cws_seq #(
    .DEPTH (DEPTH),
    .POS_W (POS_W),
    .CNT_W (CNT_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .final_i    (final_sample_i),
    .in_ready_o (in_ready_o),
    .window_i   (window_q),
    .out_free_i (out_free),
    .ctl_o      (ctl),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr),
    .count_o    (count),
    .ovf_o      (ovf),
    .pos_o      (pos)
  );

  cws_store #(
    .DEPTH        (DEPTH),
    .SAMPLE_WIDTH (SAMPLE_WIDTH),
    .ADDR_W       (POS_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (wr_addr),
    .wdata_i (sample_i),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  cws_accum #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
  ) u_accum (
    .clk_i   (clk_i),
    .ctl_i   (ctl),
    .rdata_i (rdata),
    .total_o (total)
  );

  // output beat valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (ctl.emit) begin
      ovalid_q <= 1'b1;
    end else if (out_ready_i) begin
      ovalid_q <= 1'b0;
    end
  end

  // output beat payload
  always_ff @(posedge clk_i) begin
    if (ctl.emit) begin
      total_q <= total;
      pos_q   <= pos;
      end_q   <= ctl.last;
      trunc_q <= ovf;
    end
  end

  assign out_valid_o    = ovalid_q;
  assign window_total_o = total_q;
  assign position_o     = pos_q;
  assign run_end_o      = end_q;
  assign truncated_o    = trunc_q;

  // fill count never exceeds the memory depth
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= CNT_W'(DEPTH))
    else $error("fill count above depth");

  // after the final position the block takes input again
  a_end_to_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl.emit && ctl.last) |=> in_ready_o)
    else $error("not ready after final position");

  // no memory read is in flight while loading
  a_no_read_in_load: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !ctl.acc_add)
    else $error("accumulate during load");

  // a beat is only emitted into a free output register
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctl.emit |-> (!out_valid_o || out_ready_i))
    else $error("emit over a pending beat");

endmodule
